// ===== rtl/core/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the deadline timer queue
// Entry layout, cell control, operation and result codes, divider constants.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int TIME_W    = 64;
    localparam int HANDLER_W = 8;
    localparam int TAG_W     = 16;
    localparam int MS_W      = 32;
    localparam int HZ_W      = 32;

    // Division of a 32-bit value by 1000: multiply by ceil(2^38/1000), keep bits 38 and up.
    localparam int                DIV_SHIFT = 38;
    localparam int                MAGIC_W   = 29;
    localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'd274877907;
    localparam int                DIVP_W    = HZ_W + MAGIC_W;
    localparam int                Q_W       = DIVP_W - DIV_SHIFT;

    // Idle compare period: ten seconds of timebase ticks.
    localparam int               HZ10_W     = HZ_W + 4;
    localparam logic [3:0]       IDLE_SECS  = 4'd10;

    localparam int PROD_W = Q_W + MS_W;

    localparam logic OP_ARM  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] KIND_EXPIRED = 2'd0;
    localparam logic [1:0] KIND_COMPARE = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    localparam int         ADDR_W       = 3;
    localparam logic       REG_TIMEBASE = 1'b0;

    typedef struct packed {
        logic [TIME_W-1:0]    deadline;
        logic [HANDLER_W-1:0] handler;
        logic [TAG_W-1:0]     tag;
    } entry_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/dtq_cell.sv =====
// ----------------------------------------------------------------------------
// dtq_cell: one slot of the sorted deadline chain
// Holds one entry; on insert it takes the new entry or its lower neighbor's,
// on pop it takes its upper neighbor's.
// ----------------------------------------------------------------------------
module dtq_cell
(
    input  logic               clk,
    input  dtq_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  logic               prev_after,
    input  dtq_pkg::entry_t    new_entry,
    input  dtq_pkg::entry_t    prev_entry,
    input  dtq_pkg::entry_t    next_entry,
    output dtq_pkg::entry_t    entry,
    output logic               after
);

    dtq_pkg::entry_t entry_reg;
    dtq_pkg::entry_t entry_next;

    // This slot lies at or behind the insert position; ties stay in front.
    assign after = !occupied || (entry_reg.deadline > new_entry.deadline);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins && after)
        begin
            entry_next = prev_after ? prev_entry : new_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/core/dtq_chain.sv =====
// ----------------------------------------------------------------------------
// dtq_chain: row of DEPTH cells kept sorted by deadline
// Wires each cell to its neighbors and derives slot occupancy from the count.
// ----------------------------------------------------------------------------
module dtq_chain #(
    parameter int DEPTH = 16,
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dtq_pkg::cell_ctrl_t ctrl,
    input  logic [CW-1:0]       count,
    input  dtq_pkg::entry_t     new_entry,
    output dtq_pkg::entry_t     head,
    output logic                head_after
);

    dtq_pkg::entry_t entries [DEPTH];
    logic            after   [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            dtq_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (count > CW'(i)),
                .prev_after ((i == 0) ? 1'b0 : after[(i == 0) ? 0 : i - 1]),
                .new_entry  (new_entry),
                .prev_entry ((i == 0) ? new_entry : entries[(i == 0) ? 0 : i - 1]),
                .next_entry ((i == DEPTH - 1) ? entries[i] :
                             entries[(i == DEPTH - 1) ? i : i + 1]),
                .entry      (entries[i]),
                .after      (after[i])
            );
        end
    endgenerate

    assign head       = entries[0];
    assign head_after = after[0];

    // The two front slots, when both hold entries, are in deadline order.
    a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count >= CW'(2)) |-> (entries[0].deadline <= entries[1].deadline))
        else $error("front of deadline chain out of order");

endmodule

// ===== rtl/core/deadline_timer_queue_unit.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_queue_unit: sorted queue of pending timeouts
// Arms timeouts into a chain of cells sorted by deadline and pops expired
// entries on each timer tick, reporting compare values for the timer.
//
//   Channel   Direction  Accept when           Contents
//   s_*       in         s_tvalid & s_tready   arm or tick item
//   m_*       out        m_tvalid & m_tready   expired, compare or reject item
//   APB       in         psel&penable&pwrite   timebase_hz at address 0
//
// An arm item goes through product, deadline sum, then the insert, in which
// every cell shifts at once. A tick item pops one entry per cycle through the
// head cell, unless the result register stalls, and ends with a compare result.
// Reset clears the entry count and timebase_hz; cell contents are not cleared.
// A stalled result register holds the sequencer until it drains.
// ----------------------------------------------------------------------------
module deadline_timer_queue_unit #(
    parameter int DEPTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: now_time[63:0], delay_ms[95:64], handler_id[103:96], tag[119:104]
    input  logic [119:0] s_tdata,
    // s_tuser: opcode[0]
    input  logic [0:0]   s_tuser,
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: out_handler[7:0], out_tag[23:8], compare_time[87:24]
    output logic [87:0]  m_tdata,
    // m_tuser: kind[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dtq_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ADD  = 5'b00100,
        S_INS  = 5'b01000,
        S_POP  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // ------------------------------------------------------------------
    // Configuration. The quotient hz/1000 and the ten-second period are
    // derived once at the write, so arm items need only one multiply.
    // ------------------------------------------------------------------
    logic [dtq_pkg::HZ_W-1:0]   hz_reg;
    logic [dtq_pkg::Q_W-1:0]    q_reg;
    logic [dtq_pkg::HZ10_W-1:0] hz10_reg;
    logic [dtq_pkg::DIVP_W-1:0] div_prod;
    logic                       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == dtq_pkg::REG_TIMEBASE);
    assign div_prod  = dtq_pkg::DIVP_W'(pwdata) * dtq_pkg::DIVP_W'(dtq_pkg::DIV_MAGIC);
    assign prdata    = (paddr[2] == dtq_pkg::REG_TIMEBASE) ? hz_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hz_reg   <= '0;
            q_reg    <= '0;
            hz10_reg <= '0;
        end
        else if (cfg_write)
        begin
            hz_reg   <= pwdata;
            q_reg    <= div_prod[dtq_pkg::DIV_SHIFT +: dtq_pkg::Q_W];
            hz10_reg <= dtq_pkg::HZ10_W'(pwdata) * dtq_pkg::HZ10_W'(dtq_pkg::IDLE_SECS);
        end
    end

    // ------------------------------------------------------------------
    // Item capture and the deadline datapath.
    // ------------------------------------------------------------------
    logic [dtq_pkg::TIME_W-1:0]    now_reg;
    logic [dtq_pkg::MS_W-1:0]      ms_reg;
    logic [dtq_pkg::HANDLER_W-1:0] hid_reg;
    logic [dtq_pkg::TAG_W-1:0]     tag_reg;
    logic [dtq_pkg::PROD_W-1:0]    prod_reg;
    logic [dtq_pkg::TIME_W-1:0]    dl_reg;
    logic                          s_accept;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            now_reg <= s_tdata[63:0];
            ms_reg  <= s_tdata[95:64];
            hid_reg <= s_tdata[103:96];
            tag_reg <= s_tdata[119:104];
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= dtq_pkg::PROD_W'(q_reg) * dtq_pkg::PROD_W'(ms_reg);
        end
        if (state_reg == S_ADD)
        begin
            dl_reg <= now_reg + dtq_pkg::TIME_W'(prod_reg);
        end
    end

    // ------------------------------------------------------------------
    // Cell chain.
    // ------------------------------------------------------------------
    dtq_pkg::cell_ctrl_t ctrl;
    dtq_pkg::entry_t     new_entry;
    dtq_pkg::entry_t     head;
    logic                head_after;
    logic [CW-1:0]       count_reg, count_next;

    assign new_entry.deadline = dl_reg;
    assign new_entry.handler  = hid_reg;
    assign new_entry.tag      = tag_reg;

    dtq_chain #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .count      (count_reg),
        .new_entry  (new_entry),
        .head       (head),
        .head_after (head_after)
    );

    // ------------------------------------------------------------------
    // Sequencer. A result is produced only when the output register is
    // empty or being drained in the same cycle.
    // ------------------------------------------------------------------
    logic                          out_free;
    logic                          emit;
    logic [1:0]                    e_kind;
    logic [dtq_pkg::HANDLER_W-1:0] e_handler;
    logic [dtq_pkg::TAG_W-1:0]     e_tag;
    logic [dtq_pkg::TIME_W-1:0]    e_cmp;
    logic                          e_last;
    logic                          queue_full;
    logic                          head_expired;

    logic                          m_valid_reg;
    logic [1:0]                    kind_reg;
    logic [dtq_pkg::HANDLER_W-1:0] handler_reg;
    logic [dtq_pkg::TAG_W-1:0]     otag_reg;
    logic [dtq_pkg::TIME_W-1:0]    cmp_reg;
    logic                          last_reg;

    assign out_free     = !m_valid_reg || m_tready;
    assign queue_full   = (count_reg == CW'(DEPTH));
    assign head_expired = (count_reg != '0) && (head.deadline <= now_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ctrl       = '0;
        emit       = 1'b0;
        e_kind     = dtq_pkg::KIND_COMPARE;
        e_handler  = '0;
        e_tag      = '0;
        e_cmp      = '0;
        e_last     = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = (s_tuser[0] == dtq_pkg::OP_TICK) ? S_POP : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_INS;
            end
            S_INS:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    if (queue_full)
                    begin
                        emit   = 1'b1;
                        e_kind = dtq_pkg::KIND_REJECT;
                    end
                    else
                    begin
                        ctrl.ins   = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (head_after)
                        begin
                            emit  = 1'b1;
                            e_cmp = dl_reg;
                        end
                    end
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (head_expired)
                    begin
                        ctrl.pop   = 1'b1;
                        count_next = count_reg - CW'(1);
                        e_kind     = dtq_pkg::KIND_EXPIRED;
                        e_handler  = head.handler;
                        e_tag      = head.tag;
                        e_last     = 1'b0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        e_cmp = (count_reg != '0) ? head.deadline
                                                  : now_reg + dtq_pkg::TIME_W'(hz10_reg);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg    <= e_kind;
            handler_reg <= e_handler;
            otag_reg    <= e_tag;
            cmp_reg     <= e_cmp;
            last_reg    <= e_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {cmp_reg, otag_reg, handler_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond queue depth");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |-> !queue_full && (state_reg == S_INS))
        else $error("insert into a full chain");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |=> (count_reg == $past(count_reg) - CW'(1)) && m_tvalid)
        else $error("pop did not retire exactly one entry");

endmodule
